FILE: hdl/ope_pkg.sv
// ----------------------------------------------------------------------------
// ope_pkg
// Shared types, token codes, precedence functions and saturation helper for
// the operator precedence evaluator.
// ----------------------------------------------------------------------------
package ope_pkg;

    localparam int VALUE_W             = 16;
    localparam int WIDE_W              = 2 * VALUE_W;
    localparam int KIND_W              = 5;
    localparam int MAX_MAG             = 32767;
    localparam int DEFAULT_STACK_DEPTH = 256;
    localparam int Q_DEPTH             = 4;

    typedef enum logic [KIND_W-1:0] {
        K_NONTERM = 5'd0,
        K_ADD     = 5'd1,
        K_SUB     = 5'd2,
        K_MUL     = 5'd3,
        K_DIV     = 5'd4,
        K_AND     = 5'd5,
        K_OR      = 5'd6,
        K_OPND    = 5'd7,
        K_LPAREN  = 5'd8,
        K_RPAREN  = 5'd9,
        K_END     = 5'd10,
        K_GT      = 5'd11,
        K_LT      = 5'd12,
        K_GE      = 5'd13,
        K_LE      = 5'd14,
        K_EQ      = 5'd15,
        K_NE      = 5'd16,
        K_NEG     = 5'd17,
        K_NOT     = 5'd18
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_REDUCE,
        ST_EVAL,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0]         token_kind;
        logic signed [VALUE_W-1:0] token_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] answer;
        logic                      overflow;
    } t_out_item;

    // classified token
    typedef struct packed {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value;
    } t_token;

    // stack entry; term is the topmost terminal at or below this entry
    typedef struct packed {
        t_kind                     kind;
        logic signed [VALUE_W-1:0] value;
        t_kind                     term;
    } t_entry;

    typedef struct packed {
        logic                      start;
        logic signed [VALUE_W-1:0] dividend;
        logic signed [VALUE_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] quotient;
    } t_div_rsp;

    // stack-side precedence
    function automatic logic [KIND_W-1:0] prec_f(t_kind k);
        logic [KIND_W-1:0] p;
        case (k)
            K_ADD, K_SUB:                      p = 5'd11;
            K_MUL, K_DIV:                      p = 5'd13;
            K_AND:                             p = 5'd5;
            K_OR:                              p = 5'd3;
            K_OPND, K_RPAREN:                  p = 5'd16;
            K_GT, K_LT, K_GE, K_LE:            p = 5'd9;
            K_EQ, K_NE:                        p = 5'd7;
            K_NEG, K_NOT:                      p = 5'd14;
            default:                           p = 5'd0;
        endcase
        return p;
    endfunction

    // input-side precedence
    function automatic logic [KIND_W-1:0] prec_g(t_kind k);
        logic [KIND_W-1:0] p;
        case (k)
            K_ADD, K_SUB:                      p = 5'd10;
            K_MUL, K_DIV:                      p = 5'd12;
            K_AND:                             p = 5'd4;
            K_OR:                              p = 5'd2;
            K_OPND, K_LPAREN:                  p = 5'd17;
            K_GT, K_LT, K_GE, K_LE:            p = 5'd8;
            K_EQ, K_NE:                        p = 5'd6;
            K_NEG, K_NOT:                      p = 5'd15;
            default:                           p = 5'd0;
        endcase
        return p;
    endfunction

    function automatic logic signed [VALUE_W-1:0] sat_mag(logic signed [WIDE_W-1:0] v);
        logic signed [VALUE_W-1:0] r;
        if (v > MAX_MAG) begin
            r = VALUE_W'(MAX_MAG);
        end else if (v < -MAX_MAG) begin
            r = VALUE_W'(-MAX_MAG);
        end else begin
            r = VALUE_W'(v);
        end
        return r;
    endfunction

endpackage

FILE: hdl/ope_front.sv
// ----------------------------------------------------------------------------
// ope_front
// Input stage: accepts tokens, drops undefined kinds, clamps operand values
// and zeroes the value of operator tokens, then hands them to the queue.
// ----------------------------------------------------------------------------
module ope_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ope_pkg::t_in_item i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output ope_pkg::t_token   o_tok
);

    logic            r_valid;
    logic            n_valid;
    ope_pkg::t_token r_tok;
    ope_pkg::t_token n_tok;
    logic            accept;
    logic            kind_ok;

    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign kind_ok    = (i_in.token_kind != ope_pkg::K_NONTERM) &&
                        (i_in.token_kind <= ope_pkg::K_NOT);

    always_comb begin
        n_tok.kind  = ope_pkg::t_kind'(i_in.token_kind);
        n_tok.value = '0;
        if (i_in.token_kind == ope_pkg::K_OPND) begin
            if (i_in.token_value < -ope_pkg::MAX_MAG) begin
                n_tok.value = ope_pkg::VALUE_W'(-ope_pkg::MAX_MAG);
            end else begin
                n_tok.value = i_in.token_value;
            end
        end
    end

    // hold while the queue is full, otherwise drain and refill
    always_comb begin
        n_valid = r_valid && i_q_full;
        if (accept && kind_ok) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && kind_ok) begin
            r_tok <= n_tok;
        end
    end

    assign o_push = r_valid;
    assign o_tok  = r_tok;

endmodule

FILE: hdl/ope_queue.sv
// ----------------------------------------------------------------------------
// ope_queue
// Small token FIFO that decouples the input stage from the stack engine.
// ----------------------------------------------------------------------------
module ope_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ope_pkg::t_token i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output ope_pkg::t_token o_head
);

    localparam int PTR_W = $clog2(ope_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(ope_pkg::Q_DEPTH + 1);

    ope_pkg::t_token  r_mem [ope_pkg::Q_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_cnt == CNT_W'(ope_pkg::Q_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(ope_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(ope_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

FILE: hdl/ope_divider.sv
// ----------------------------------------------------------------------------
// ope_divider
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle,
// truncating toward zero. The divisor is never zero here.
// ----------------------------------------------------------------------------
module ope_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ope_pkg::t_div_req i_req,
    output ope_pkg::t_div_rsp o_rsp
);

    localparam int MAG_W = ope_pkg::VALUE_W - 1;
    localparam int CNT_W = $clog2(MAG_W + 1);

    logic                              r_busy;
    logic                              r_done;
    logic [CNT_W-1:0]                  r_cnt;
    logic [MAG_W-1:0]                  r_rem;
    logic [MAG_W-1:0]                  r_quo;
    logic [MAG_W-1:0]                  r_dvs;
    logic                              r_neg;
    logic [MAG_W:0]                    shifted;
    logic [MAG_W:0]                    diff;
    logic                              fits;
    logic [MAG_W-1:0]                  mag_a;
    logic [MAG_W-1:0]                  mag_b;
    logic signed [ope_pkg::VALUE_W-1:0] q_pos;

    assign mag_a = i_req.dividend[ope_pkg::VALUE_W-1] ? MAG_W'(-i_req.dividend)
                                                      : MAG_W'(i_req.dividend);
    assign mag_b = i_req.divisor[ope_pkg::VALUE_W-1]  ? MAG_W'(-i_req.divisor)
                                                      : MAG_W'(i_req.divisor);

    assign shifted = {r_rem, r_quo[MAG_W-1]};
    assign fits    = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(MAG_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= mag_a;
            r_dvs <= mag_b;
            r_neg <= i_req.dividend[ope_pkg::VALUE_W-1] ^ i_req.divisor[ope_pkg::VALUE_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
            r_quo <= {r_quo[MAG_W-2:0], fits};
        end
    end

    assign q_pos          = $signed({1'b0, r_quo});
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? -q_pos : q_pos;

endmodule

FILE: hdl/ope_engine.sv
// ----------------------------------------------------------------------------
// ope_engine
// Back end: token stack with cached top entry, shift/reduce sequencer,
// reduction evaluator and the result register.
// ----------------------------------------------------------------------------
module ope_engine #(
    parameter int STACK_DEPTH = ope_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  ope_pkg::t_token    i_q_head,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ope_pkg::t_out_item o_out
);

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam int VW   = ope_pkg::VALUE_W;
    localparam ope_pkg::t_entry END_ENTRY = '{kind: ope_pkg::K_END, value: '0,
                                              term: ope_pkg::K_END};

    ope_pkg::t_state    r_state;
    ope_pkg::t_state    n_state;

    ope_pkg::t_entry    r_mem [STACK_DEPTH];
    ope_pkg::t_entry    r_top;
    ope_pkg::t_entry    r_rdata;
    logic               r_in_mem;
    logic [SP_W-1:0]    r_sp;
    ope_pkg::t_token    r_tok;
    ope_pkg::t_token    r_buf [3];
    logic [1:0]         r_n;
    logic               r_ovf;
    logic               r_out_valid;
    ope_pkg::t_out_item r_out;

    ope_pkg::t_entry    top_view;
    ope_pkg::t_kind     last_kind;
    logic [ope_pkg::KIND_W-1:0] f_top;
    logic [ope_pkg::KIND_W-1:0] g_tok;
    logic [ope_pkg::KIND_W-1:0] g_last;
    logic               tok_end;
    logic               sp_full;
    logic               can_more;
    logic               pop_while;
    logic               pop_last;
    logic               shift_ok;
    logic               out_free;
    logic               is_div_op;

    logic signed [VW-1:0]              opa;
    logic signed [VW-1:0]              opb;
    logic signed [ope_pkg::WIDE_W-1:0] prod;
    logic signed [VW-1:0]              ev;

    // sequencer controls
    logic               tok_take;
    logic               clr_n;
    logic               pop_en;
    logic               push_en;
    ope_pkg::t_entry    push_entry;
    logic               set_ovf;
    logic               emit;

    ope_pkg::t_div_req  div_req;
    ope_pkg::t_div_rsp  div_rsp;

    ope_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // after a pop the new top sits in the read register
    assign top_view = r_in_mem ? r_rdata : r_top;

    always_comb begin
        case (r_n)
            2'd1:    last_kind = r_buf[0].kind;
            2'd2:    last_kind = r_buf[1].kind;
            default: last_kind = r_buf[2].kind;
        endcase
    end

    assign f_top     = ope_pkg::prec_f(top_view.term);
    assign g_tok     = ope_pkg::prec_g(r_tok.kind);
    assign g_last    = ope_pkg::prec_g(last_kind);
    assign tok_end   = r_tok.kind == ope_pkg::K_END;
    assign sp_full   = r_sp == SP_W'(STACK_DEPTH - 1);
    assign can_more  = (r_n != 2'd3) && (r_sp != '0);
    assign pop_while = can_more && ((r_n == 2'd0) || (f_top >= g_last));
    assign pop_last  = can_more && (top_view.kind == ope_pkg::K_NONTERM);
    assign shift_ok  = f_top <= g_tok;
    assign out_free  = !r_out_valid || !i_out_stall;

    // reduction evaluator
    assign opa  = r_buf[2].value;
    assign opb  = r_buf[0].value;
    assign prod = opa * opb;
    assign is_div_op = (r_n == 2'd3) && (r_buf[0].kind == ope_pkg::K_NONTERM) &&
                       (r_buf[1].kind == ope_pkg::K_DIV) && (opb != '0);

    always_comb begin
        ev = '0;
        case (r_n)
            2'd3: begin
                if (r_buf[0].kind != ope_pkg::K_NONTERM) begin
                    ev = r_buf[1].value;
                end else begin
                    case (r_buf[1].kind)
                        ope_pkg::K_ADD: ev = ope_pkg::sat_mag(ope_pkg::WIDE_W'(opa) +
                                                              ope_pkg::WIDE_W'(opb));
                        ope_pkg::K_SUB: ev = ope_pkg::sat_mag(ope_pkg::WIDE_W'(opa) -
                                                              ope_pkg::WIDE_W'(opb));
                        ope_pkg::K_MUL: ev = ope_pkg::sat_mag(prod);
                        ope_pkg::K_AND: ev = VW'((opa != '0) && (opb != '0));
                        ope_pkg::K_OR:  ev = VW'((opa != '0) || (opb != '0));
                        ope_pkg::K_GT:  ev = VW'(opa > opb);
                        ope_pkg::K_LT:  ev = VW'(opa < opb);
                        ope_pkg::K_GE:  ev = VW'(opa >= opb);
                        ope_pkg::K_LE:  ev = VW'(opa <= opb);
                        ope_pkg::K_EQ:  ev = VW'(opa == opb);
                        ope_pkg::K_NE:  ev = VW'(opa != opb);
                        default:        ev = '0;
                    endcase
                end
            end
            2'd2: begin
                if (r_buf[1].kind == ope_pkg::K_NEG) begin
                    ev = ope_pkg::sat_mag(-ope_pkg::WIDE_W'(opb));
                end else begin
                    ev = VW'(opb == '0);
                end
            end
            2'd1:    ev = opb;
            default: ev = '0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ope_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    n_state = ope_pkg::ST_DECIDE;
                end
            end
            ope_pkg::ST_DECIDE: begin
                if (tok_end) begin
                    n_state = (r_sp > SP_W'(1)) ? ope_pkg::ST_REDUCE : ope_pkg::ST_EMIT;
                end else begin
                    n_state = shift_ok ? ope_pkg::ST_IDLE : ope_pkg::ST_REDUCE;
                end
            end
            ope_pkg::ST_REDUCE: begin
                if (!pop_while) begin
                    n_state = ope_pkg::ST_EVAL;
                end
            end
            ope_pkg::ST_EVAL: begin
                n_state = is_div_op ? ope_pkg::ST_DIV : ope_pkg::ST_DECIDE;
            end
            ope_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ope_pkg::ST_DECIDE;
                end
            end
            ope_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = ope_pkg::ST_IDLE;
                end
            end
            default: n_state = ope_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        tok_take         = 1'b0;
        clr_n            = 1'b0;
        pop_en           = 1'b0;
        push_en          = 1'b0;
        push_entry.kind  = ope_pkg::K_NONTERM;
        push_entry.value = ev;
        push_entry.term  = top_view.term;
        set_ovf          = 1'b0;
        emit             = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = opa;
        div_req.divisor  = opb;
        case (r_state)
            ope_pkg::ST_IDLE: begin
                tok_take = !i_q_empty;
            end
            ope_pkg::ST_DECIDE: begin
                if (!tok_end && shift_ok) begin
                    // drop the shift and flag it when the stack is full
                    if (sp_full) begin
                        set_ovf = 1'b1;
                    end else begin
                        push_en          = 1'b1;
                        push_entry.kind  = r_tok.kind;
                        push_entry.value = r_tok.value;
                        push_entry.term  = r_tok.kind;
                    end
                end else begin
                    clr_n = 1'b1;
                end
            end
            ope_pkg::ST_REDUCE: begin
                pop_en = pop_while || pop_last;
            end
            ope_pkg::ST_EVAL: begin
                if (is_div_op) begin
                    div_req.start = 1'b1;
                end else begin
                    push_en = 1'b1;
                end
            end
            ope_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    push_en          = 1'b1;
                    push_entry.value = div_rsp.quotient;
                end
            end
            ope_pkg::ST_EMIT: begin
                emit = out_free;
            end
            default: begin
                tok_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ope_pkg::ST_IDLE;
            r_sp        <= '0;
            r_top       <= END_ENTRY;
            r_in_mem    <= 1'b0;
            r_n         <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (clr_n) begin
                r_n <= '0;
            end
            if (pop_en) begin
                r_n      <= r_n + 1'b1;
                r_sp     <= r_sp - 1'b1;
                r_in_mem <= 1'b1;
            end
            if (push_en) begin
                r_top    <= push_entry;
                r_in_mem <= 1'b0;
                r_sp     <= r_sp + 1'b1;
            end
            if (set_ovf) begin
                r_ovf <= 1'b1;
            end
            if (emit) begin
                r_sp        <= '0;
                r_top       <= END_ENTRY;
                r_in_mem    <= 1'b0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tok_take) begin
            r_tok <= i_q_head;
        end
        if (pop_en) begin
            r_buf[r_n].kind  <= top_view.kind;
            r_buf[r_n].value <= top_view.value;
        end
        if (emit) begin
            r_out.answer   <= (r_sp == SP_W'(1)) ? top_view.value : '0;
            r_out.overflow <= r_ovf;
        end
    end

    // stack memory below the cached top
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_sp] <= top_view;
        end
        if (pop_en) begin
            r_rdata <= r_mem[SP_W'(r_sp - 1'b1)];
        end
    end

    assign o_q_pop     = tok_take;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hdl/operator_precedence_evaluator.sv
// ----------------------------------------------------------------------------
// operator_precedence_evaluator
// Evaluates an infix token stream with a shift/reduce stack machine and
// gives the value of the expression on the end token.
//
//   channel | valid       | stall       | payload
//   --------+-------------+-------------+--------------------------------
//   input   | i_in_valid  | o_in_stall  | i_in  (token_kind, token_value)
//   output  | o_out_valid | i_out_stall | o_out (answer, overflow)
//
// A shifted token passes through a fetch step and a decide step. Each reduction
// adds a decide step, an evaluate step and one pop per popped stack entry,
// plus a step to close the handle unless its last pop takes a nonterminal;
// a division adds a divider run and the end token one result load.
// Reset is synchronous and needs no clearing pass; the stack starts empty.
// A four-entry queue keeps tokens arriving while the engine reduces or waits.
// ----------------------------------------------------------------------------
module operator_precedence_evaluator #(
    parameter int STACK_DEPTH = ope_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ope_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ope_pkg::t_out_item o_out
);

    logic            f_push;
    ope_pkg::t_token f_tok;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;
    ope_pkg::t_token q_head;

    ope_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_q_full   (q_full),
        .o_push     (f_push),
        .o_tok      (f_tok)
    );

    ope_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  (f_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    ope_engine #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
